// ----- sv/rmq_pkg.sv -----
package rmq_pkg;

	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	// Sums of three Q2.14 entries plus one need 18 signed bits.
	localparam int CMP_W = 18;
	// A positive s stays below 2^17.
	localparam int S_W = 17;
	// Leading-one position of s and its halved even part.
	localparam int LEAD_W = 5;
	localparam int QH_W   = LEAD_W - 1;

	localparam int COMP_WIDTH_DEF   = 16;
	localparam int NEWTON_STEPS_DEF = 3;

	localparam int IN_TDATA_W  = 9 * IN_W;
	localparam int OUT_TDATA_W = 4 * OUT_W;
	localparam int OUT_TUSER_W = 3;

	localparam logic signed [CMP_W-1:0] ONE_Q14 = 18'sd16384;
	localparam logic [OUT_W-1:0] SAT_MAX = 16'h7FFF;
	localparam logic [OUT_W-1:0] SAT_MIN = 16'h8000;

	typedef enum logic [1:0] {
		CASE_W = 2'd0,
		CASE_Z = 2'd1,
		CASE_X = 2'd2,
		CASE_Y = 2'd3
	} dom_case_t;

	// Packed so that m00 sits in the lowest bits.
	typedef struct packed {
		logic signed [IN_W-1:0] m22;
		logic signed [IN_W-1:0] m21;
		logic signed [IN_W-1:0] m20;
		logic signed [IN_W-1:0] m12;
		logic signed [IN_W-1:0] m11;
		logic signed [IN_W-1:0] m10;
		logic signed [IN_W-1:0] m02;
		logic signed [IN_W-1:0] m01;
		logic signed [IN_W-1:0] m00;
	} mat_t;

	// Sideband that rides along the reciprocal square root pipeline.
	typedef struct packed {
		logic signed [CMP_W-1:0] cx;
		logic signed [CMP_W-1:0] cy;
		logic signed [CMP_W-1:0] cz;
		logic signed [CMP_W-1:0] cw;
		logic [QH_W-1:0]         qh;
		dom_case_t               dc;
		logic                    bad;
	} side_t;

	typedef struct packed {
		logic                    bad;
		dom_case_t               dc;
		logic [OUT_W-1:0]        qw;
		logic [OUT_W-1:0]        qz;
		logic [OUT_W-1:0]        qy;
		logic [OUT_W-1:0]        qx;
	} res_t;

endpackage

// ----- sv/rmq_front.sv -----
module rmq_front
	import rmq_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mat_t                  mat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COMP_WIDTH+1:0] m_norm,
	output side_t                 side
);

	logic signed [CMP_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [CMP_W-1:0] a, b, c, s;
	side_t                   side_c;

	logic                    v_s1, v_s2;
	logic                    en_s1, en_s2;
	side_t                   side_s1, side_s2;
	logic [S_W-1:0]          sv_s1;
	logic [COMP_WIDTH+1:0]   m_s2;

	logic [LEAD_W-1:0]       lead;
	logic [LEAD_W-1:0]       qsh;
	logic [S_W+COMP_WIDTH-1:0] wide;
	side_t                   side_n;

	assign e00 = CMP_W'(mat.m00);
	assign e01 = CMP_W'(mat.m01);
	assign e02 = CMP_W'(mat.m02);
	assign e10 = CMP_W'(mat.m10);
	assign e11 = CMP_W'(mat.m11);
	assign e12 = CMP_W'(mat.m12);
	assign e20 = CMP_W'(mat.m20);
	assign e21 = CMP_W'(mat.m21);
	assign e22 = CMP_W'(mat.m22);

	// Case selection and the unnormalized quaternion.
	always_comb begin
		side_c    = '0;
		side_c.qh = '0;
		if (!e22[CMP_W-1]) begin
			a = e00 + e11;
			b = e10 - e01;
			c = ONE_Q14 + e22;
			if (!a[CMP_W-1]) begin
				s         = c + a;
				side_c.cx = e21 - e12;
				side_c.cy = e02 - e20;
				side_c.cz = b;
				side_c.cw = s;
				side_c.dc = CASE_W;
			end else begin
				s         = c - a;
				side_c.cx = e02 + e20;
				side_c.cy = e21 + e12;
				side_c.cz = s;
				side_c.cw = b;
				side_c.dc = CASE_Z;
			end
		end else begin
			a = e00 - e11;
			b = e10 + e01;
			c = ONE_Q14 - e22;
			if (!a[CMP_W-1] && (a != '0)) begin
				s         = c + a;
				side_c.cx = s;
				side_c.cy = b;
				side_c.cz = e02 + e20;
				side_c.cw = e21 - e12;
				side_c.dc = CASE_X;
			end else begin
				s         = c - a;
				side_c.cx = b;
				side_c.cy = s;
				side_c.cz = e21 + e12;
				side_c.cw = e02 - e20;
				side_c.dc = CASE_Y;
			end
		end
		side_c.bad = s[CMP_W-1] || (s == '0);
	end

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= side_c;
			sv_s1   <= s[S_W-1:0];
		end
	end

	// Normalize s to m in [1,4) by an even shift.
	always_comb begin
		lead = '0;
		for (int i = 0; i < S_W; i++) begin
			if (sv_s1[i]) begin
				lead = LEAD_W'(i);
			end
		end
		qsh  = {lead[LEAD_W-1:1], 1'b0};
		wide = {sv_s1, {COMP_WIDTH{1'b0}}} >> qsh;
		side_n    = side_s1;
		side_n.qh = lead[LEAD_W-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			m_s2    <= wide[COMP_WIDTH+1:0];
			side_s2 <= side_n;
		end
	end

	assign out_valid = v_s2;
	assign m_norm    = m_s2;
	assign side      = side_s2;

`ifndef SYNTHESIS
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s2 && v_s1 && !side_s1.bad) |=> (m_s2[COMP_WIDTH+1:COMP_WIDTH] != 2'b00))
		else $error("normalized s below one");
`endif

endmodule

// ----- sv/rmq_seed.sv -----
module rmq_seed
	import rmq_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COMP_WIDTH+1:0] m_in,
	input  side_t                 side_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COMP_WIDTH+1:0] m_out,
	output logic [COMP_WIDTH:0]   y_out,
	output side_t                 side_out
);

	localparam int F    = COMP_WIDTH;
	localparam int NW   = F + 3;
	localparam int HW   = F + 2;
	localparam int NDIG = (HW + 7) / 8;
	localparam int PW   = NDIG * 8;
	localparam logic [NW-1:0] SEVEN  = {3'b111, {F{1'b0}}};
	localparam logic [F:0]    Y_ONE  = {1'b1, {F{1'b0}}};
	localparam logic [F:0]    Y_HALF = {2'b01, {(F-1){1'b0}}};

	logic [NW-1:0] num;
	logic [PW-1:0] half_p, quo;
	logic [1:0]    rem;
	logic [9:0]    dv, r10;
	logic [19:0]   prod;
	logic [7:0]    qd;

	logic          v_s1, en_s1;
	logic [F+1:0]  m_s1;
	logic [F:0]    y_s1;
	side_t         side_s1;

	// Seed (7 - m)/6: halve, then divide by three one byte at a time.
	always_comb begin
		num    = SEVEN - NW'(m_in);
		half_p = PW'(num[NW-1:1]);
		quo    = '0;
		rem    = '0;
		dv     = '0;
		prod   = '0;
		qd     = '0;
		r10    = '0;
		for (int k = NDIG - 1; k >= 0; k--) begin
			dv   = {rem, half_p[k*8 +: 8]};
			prod = 20'(dv) * 20'd683;
			qd   = prod[18:11];
			r10  = dv - 10'(qd) * 10'd3;
			rem  = r10[1:0];
			quo[k*8 +: 8] = qd;
		end
	end

	assign en_s1    = !v_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y_s1    <= quo[F:0];
			m_s1    <= m_in;
			side_s1 <= side_in;
		end
	end

	assign out_valid = v_s1;
	assign m_out     = m_s1;
	assign y_out     = y_s1;
	assign side_out  = side_s1;

`ifndef SYNTHESIS
	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !side_in.bad) |=> ((y_s1 >= Y_HALF) && (y_s1 <= Y_ONE)))
		else $error("seed outside one half to one");
`endif

endmodule

// ----- sv/rmq_newton.sv -----
module rmq_newton
	import rmq_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COMP_WIDTH+1:0] m_in,
	input  logic [COMP_WIDTH:0]   y_in,
	input  side_t                 side_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COMP_WIDTH+1:0] m_out,
	output logic [COMP_WIDTH:0]   y_out,
	output side_t                 side_out
);

	localparam int F  = COMP_WIDTH;
	localparam int YW = F + 1;
	localparam int MW = F + 2;
	localparam int TW = F + 1;
	localparam int UW = F + 3;
	localparam int DW = F + 2;
	localparam logic [UW-1:0] THREE = UW'({2'b11, {F{1'b0}}});

	logic [2*YW-1:0]  pyy;
	logic [MW+TW-1:0] pmt;
	logic [YW+DW-1:0] pyd;
	logic [UW-1:0]    dfull;
	logic [DW-1:0]    d;

	logic             v_s1, v_s2, v_s3;
	logic             en_s1, en_s2, en_s3;
	logic [TW-1:0]    t_s1;
	logic [UW-1:0]    u_s2;
	logic [YW-1:0]    y_s1, y_s2, y_s3;
	logic [MW-1:0]    m_s1, m_s2, m_s3;
	side_t            side_s1, side_s2, side_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// t = y*y
	assign pyy = (2*YW)'(y_in) * (2*YW)'(y_in);
	// u = m*t
	assign pmt = (MW+TW)'(m_s1) * (MW+TW)'(t_s1);
	// d = 3 - u, floored at zero, then y = y*d/2
	assign dfull = THREE - u_s2;
	assign d     = (u_s2 > THREE) ? '0 : dfull[DW-1:0];
	assign pyd   = (YW+DW)'(y_s2) * (YW+DW)'(d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			t_s1    <= pyy[F +: TW];
			y_s1    <= y_in;
			m_s1    <= m_in;
			side_s1 <= side_in;
		end
		if (en_s2) begin
			u_s2    <= pmt[F +: UW];
			y_s2    <= y_s1;
			m_s2    <= m_s1;
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			y_s3    <= pyd[F+1 +: YW];
			m_s3    <= m_s2;
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign m_out     = m_s3;
	assign y_out     = y_s3;
	assign side_out  = side_s3;

endmodule

// ----- sv/rmq_scale.sv -----
module rmq_scale
	import rmq_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [COMP_WIDTH:0] y_in,
	input  side_t               side_in,
	output logic                out_valid,
	input  logic                out_ready,
	output res_t                res
);

	localparam int YW   = COMP_WIDTH + 1;
	localparam int MAGW = CMP_W + YW;
	localparam int SW   = MAGW + 1;
	// Rounding bit sits at R-1 with R = COMP_WIDTH - 6 + q/2.
	localparam int RB   = COMP_WIDTH - 7;
	localparam logic [SW-1:0] LIM_NEG = SW'(32768);
	localparam logic [SW-1:0] LIM_POS = SW'(32767);

	logic signed [CMP_W-1:0] comp [4];
	logic [CMP_W-1:0]        absv [4];
	logic [MAGW-1:0]         prod [4];
	logic [SW-1:0]           sum  [4];
	logic [SW-1:0]           rnd  [4];
	logic [OUT_W-1:0]        lo   [4];
	logic [OUT_W-1:0]        val  [4];

	logic                    v_s1, v_s2, en_s1, en_s2;
	logic [MAGW-1:0]         mag_s1 [4];
	logic [3:0]              neg_s1;
	logic [QH_W-1:0]         qh_s1;
	dom_case_t               dc_s1;
	logic                    bad_s1;
	res_t                    res_s2;

	assign comp[0] = side_in.cx;
	assign comp[1] = side_in.cy;
	assign comp[2] = side_in.cz;
	assign comp[3] = side_in.cw;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			absv[i] = comp[i][CMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
			prod[i] = MAGW'(absv[i]) * MAGW'(y_in);
		end
	end

	// Round to nearest, ties away from zero, then saturate.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum[i] = SW'(mag_s1[i]) + (SW'(1) << (RB + int'(qh_s1)));
			rnd[i] = sum[i] >> (RB + 1 + int'(qh_s1));
			lo[i]  = rnd[i][OUT_W-1:0];
			if (bad_s1) begin
				val[i] = '0;
			end else if (neg_s1[i]) begin
				val[i] = (rnd[i] > LIM_NEG) ? SAT_MIN : (~lo[i] + 1'b1);
			end else begin
				val[i] = (rnd[i] > LIM_POS) ? SAT_MAX : lo[i];
			end
		end
	end

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 4; i++) begin
				mag_s1[i] <= prod[i];
				neg_s1[i] <= comp[i][CMP_W-1];
			end
			qh_s1  <= side_in.qh;
			dc_s1  <= side_in.dc;
			bad_s1 <= side_in.bad;
		end
		if (en_s2) begin
			res_s2.qx  <= val[0];
			res_s2.qy  <= val[1];
			res_s2.qz  <= val[2];
			res_s2.qw  <= val[3];
			res_s2.dc  <= dc_s1;
			res_s2.bad <= bad_s1;
		end
	end

	assign out_valid = v_s2;
	assign res       = res_s2;

endmodule

// ----- sv/rotation_matrix_to_quaternion_top.sv -----
// Rotation matrix to quaternion converter.
//
// Slave stream: one transaction carries a 3x3 rotation matrix, nine signed
// Q2.14 entries. Master stream: one transaction per matrix with the
// quaternion (x, y, z, w, signed Q2.14, saturated), the dominant case and a
// flag for a non-positive pivot s, in which case the quaternion is zero.
//
// Throughput is one matrix per cycle while the receiver keeps up. The
// datapath is a register pipeline of 5 + 3*NEWTON_STEPS stages: case select,
// normalize, seed, three stages per Newton iteration (one multiplier each:
// y*y, m*t, y*d), output multiply and round/saturate.
//
// Reset clears only the stage valid bits; the pipeline comes up empty and
// s_axis_tready is high. When the receiver stalls, the output register holds
// its transaction; each stage keeps accepting as long as the stage after it
// is empty, so input is taken until every stage is full, and nothing is
// dropped or repeated.
module rotation_matrix_to_quaternion_top
	import rmq_pkg::*;
#(
	parameter int COMP_WIDTH   = COMP_WIDTH_DEF,
	parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22: 16 bits each from bit 0
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// quat_x, quat_y, quat_z, quat_w: 16 bits each from bit 0
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// dominant_case [1:0], bad_input [2]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	mat_t                  mat;

	logic                  fr_valid, fr_ready;
	logic [COMP_WIDTH+1:0] fr_m;
	side_t                 fr_side;

	// Newton chain: index 0 is the seed, index k+1 the output of iteration k.
	logic                  nv [NEWTON_STEPS+1];
	logic                  nr [NEWTON_STEPS+1];
	logic [COMP_WIDTH+1:0] nm [NEWTON_STEPS+1];
	logic [COMP_WIDTH:0]   ny [NEWTON_STEPS+1];
	side_t                 ns [NEWTON_STEPS+1];

	res_t                  res;

	assign mat = s_axis_tdata;

	// Select the case, form the components and normalize s.
	rmq_front #(
		.COMP_WIDTH (COMP_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mat       (mat),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.m_norm    (fr_m),
		.side      (fr_side)
	);

	// Linear seed for 1/sqrt(m).
	rmq_seed #(
		.COMP_WIDTH (COMP_WIDTH)
	) u_seed (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.m_in      (fr_m),
		.side_in   (fr_side),
		.out_valid (nv[0]),
		.out_ready (nr[0]),
		.m_out     (nm[0]),
		.y_out     (ny[0]),
		.side_out  (ns[0])
	);

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
		rmq_newton #(
			.COMP_WIDTH (COMP_WIDTH)
		) u_newton (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (nv[k]),
			.in_ready  (nr[k]),
			.m_in      (nm[k]),
			.y_in      (ny[k]),
			.side_in   (ns[k]),
			.out_valid (nv[k+1]),
			.out_ready (nr[k+1]),
			.m_out     (nm[k+1]),
			.y_out     (ny[k+1]),
			.side_out  (ns[k+1])
		);
	end

	// Scale the components by y, round, saturate and hold the result.
	rmq_scale #(
		.COMP_WIDTH (COMP_WIDTH)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nv[NEWTON_STEPS]),
		.in_ready  (nr[NEWTON_STEPS]),
		.y_in      (ny[NEWTON_STEPS]),
		.side_in   (ns[NEWTON_STEPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.qw, res.qz, res.qy, res.qx};
	assign m_axis_tuser = {res.bad, res.dc};

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.bad) |-> (m_axis_tdata == '0))
		else $error("bad input with nonzero quaternion");

	a_dom_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res.bad) |->
			((res.dc == CASE_W && !res.qw[OUT_W-1]) ||
			 (res.dc == CASE_Z && !res.qz[OUT_W-1]) ||
			 (res.dc == CASE_X && !res.qx[OUT_W-1]) ||
			 (res.dc == CASE_Y && !res.qy[OUT_W-1])))
		else $error("dominant component negative");
`endif

endmodule

// ----- test/rotation_matrix_to_quaternion_top_test.sv -----
module rotation_matrix_to_quaternion_top_test;
	import rmq_pkg::*;

	// Datapath setup of the instance; the predictor follows the same numbers.
	localparam int FRAC_W = COMP_WIDTH_DEF;
	localparam int ITERS  = NEWTON_STEPS_DEF;
	localparam longint unsigned UNIT_F = 64'd1 << FRAC_W;

	// Matrix accepted to result available, in cycles.
	localparam int LATENCY = 4 + 3 * ITERS;
	// Cycles without any transaction before the run is declared hung. The
	// longest legal quiet stretch is the long receiver hold below.
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// m00, m01, m02, m10, m11, m12, m20, m21, m22: 16 bits each from bit 0
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// quat_x, quat_y, quat_z, quat_w: 16 bits each from bit 0
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// dominant_case [1:0], bad_input [2]
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	// Predicted quaternions, oldest first.
	res_t quat_expected [$];
	int unsigned mats_sent = 0;
	int unsigned quats_seen = 0;
	int unsigned mismatches = 0;

	// Idling controls shared by the sender, the receiver and the test tasks.
	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;
	int unsigned rx_hold_req = 0;

	rotation_matrix_to_quaternion_top #(
		.COMP_WIDTH  (FRAC_W),
		.NEWTON_STEPS(ITERS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Quaternion predictor
	// ------------------------------------------------------------------

	// Exact floor(a*b / 2^F).
	function automatic longint unsigned fx_mul(input longint unsigned a,
			input longint unsigned b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return 64'(p >> FRAC_W);
	endfunction

	// Scale a Q14 component by y / 2^r, round half away from zero, saturate.
	function automatic logic [OUT_W-1:0] round_sat(input longint c,
			input longint unsigned y, input int r);
		longint unsigned mag;
		longint unsigned rnd;
		mag = 64'(c < 0 ? -c : c);
		mag = mag * y;
		rnd = (mag + (64'd1 << (r - 1))) >> r;
		if (c < 0)
			return (rnd > 64'd32768) ? SAT_MIN : OUT_W'(64'd0 - rnd);
		return (rnd > 64'd32767) ? SAT_MAX : OUT_W'(rnd);
	endfunction

	function automatic res_t predict_quat(input mat_t mt);
		longint e00, e01, e02, e10, e11, e12, e20, e21, e22;
		longint diag, off_sum, pivot_base, s, cx, cy, cz, cw;
		longint unsigned mant, y, t, u, d;
		int lead, q, r;
		dom_case_t dc;
		res_t res;
		e00 = mt.m00; e01 = mt.m01; e02 = mt.m02;
		e10 = mt.m10; e11 = mt.m11; e12 = mt.m12;
		e20 = mt.m20; e21 = mt.m21; e22 = mt.m22;
		// Pick the dominant component: m22 sign first, then the diagonal
		// sum (non-negative wins) or difference (strictly positive wins).
		if (e22 >= 0) begin
			diag = e00 + e11;
			off_sum = e10 - e01;
			pivot_base = longint'(ONE_Q14) + e22;
			if (diag >= 0) begin
				s = pivot_base + diag;
				cx = e21 - e12; cy = e02 - e20; cz = off_sum; cw = s;
				dc = CASE_W;
			end else begin
				s = pivot_base - diag;
				cx = e02 + e20; cy = e21 + e12; cz = s; cw = off_sum;
				dc = CASE_Z;
			end
		end else begin
			diag = e00 - e11;
			off_sum = e10 + e01;
			pivot_base = longint'(ONE_Q14) - e22;
			if (diag > 0) begin
				s = pivot_base + diag;
				cx = s; cy = off_sum; cz = e02 + e20; cw = e21 - e12;
				dc = CASE_X;
			end else begin
				s = pivot_base - diag;
				cx = off_sum; cy = s; cz = e21 + e12; cw = e02 - e20;
				dc = CASE_Y;
			end
		end
		res = '0;
		res.dc = dc;
		// Non-positive pivot: zero quaternion with the error flag.
		if (s <= 0) begin
			res.bad = 1'b1;
			return res;
		end
		// Normalize s into [1,4) on an even shift, seed, then Newton.
		lead = 0;
		while (lead < 40 && (s >> (lead + 1)) != 0)
			lead++;
		q = lead & ~1;
		mant = s;
		mant = (mant << FRAC_W) >> q;
		y = (7 * UNIT_F - mant) / 6;
		for (int i = 0; i < ITERS; i++) begin
			t = fx_mul(y, y);
			u = fx_mul(mant, t);
			d = (u > 3 * UNIT_F) ? 64'd0 : 3 * UNIT_F - u;
			y = fx_mul(y, d) >> 1;
		end
		r = FRAC_W + 1 + q / 2 - 7;
		res.qx = round_sat(cx, y, r);
		res.qy = round_sat(cy, y, r);
		res.qz = round_sat(cz, y, r);
		res.qw = round_sat(cw, y, r);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Matrix builders
	// ------------------------------------------------------------------

	function automatic int clamp_entry(input int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	function automatic mat_t make_mat(input int a00, input int a01, input int a02,
			input int a10, input int a11, input int a12,
			input int a20, input int a21, input int a22);
		mat_t mt;
		mt.m00 = IN_W'(a00); mt.m01 = IN_W'(a01); mt.m02 = IN_W'(a02);
		mt.m10 = IN_W'(a10); mt.m11 = IN_W'(a11); mt.m12 = IN_W'(a12);
		mt.m20 = IN_W'(a20); mt.m21 = IN_W'(a21); mt.m22 = IN_W'(a22);
		return mt;
	endfunction

	// Proper rotation from a random unit quaternion, optionally perturbed.
	function automatic mat_t random_rotation(input bit perturb);
		real qa, qb, qc, qd, n;
		real rm [9];
		int e [9];
		n = 0.0;
		while (n < 0.01 || n > 1.0) begin
			qa = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
			qb = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
			qc = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
			qd = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
			n = qa * qa + qb * qb + qc * qc + qd * qd;
		end
		n = $sqrt(n);
		qa = qa / n; qb = qb / n; qc = qc / n; qd = qd / n;
		// qa is w; qb, qc, qd are x, y, z.
		rm[0] = 1.0 - 2.0 * (qc * qc + qd * qd);
		rm[1] = 2.0 * (qb * qc - qd * qa);
		rm[2] = 2.0 * (qb * qd + qc * qa);
		rm[3] = 2.0 * (qb * qc + qd * qa);
		rm[4] = 1.0 - 2.0 * (qb * qb + qd * qd);
		rm[5] = 2.0 * (qc * qd - qb * qa);
		rm[6] = 2.0 * (qb * qd - qc * qa);
		rm[7] = 2.0 * (qc * qd + qb * qa);
		rm[8] = 1.0 - 2.0 * (qb * qb + qc * qc);
		for (int i = 0; i < 9; i++) begin
			e[i] = $rtoi(rm[i] * 16384.0 + (rm[i] < 0.0 ? -0.5 : 0.5));
			if (perturb)
				e[i] = e[i] + int'($urandom_range(0, 128)) - 64;
			e[i] = clamp_entry(e[i]);
		end
		return make_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
	endfunction

	// Diagonal sitting right at the case decision thresholds.
	function automatic mat_t near_threshold();
		int d00, d22;
		d22 = int'($urandom_range(0, 4)) - 2;
		d00 = int'($urandom_range(0, 6000)) - 3000;
		return make_mat(d00, int'($urandom) >>> 16, int'($urandom) >>> 16,
			int'($urandom) >>> 16, -d00 + int'($urandom_range(0, 4)) - 2,
			int'($urandom) >>> 16, int'($urandom) >>> 16,
			int'($urandom) >>> 16, d22);
	endfunction

	// Mostly short idles, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// Sender, receiver, checker, watchdog
	// ------------------------------------------------------------------

	// Offer one matrix, hold it until the transaction completes, then record
	// its prediction and maybe idle. Called right after a rising edge.
	task automatic send_matrix(input mat_t mt);
		int unsigned gap;
		s_axis_tdata <= mt;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		quat_expected.push_back(predict_quat(mt));
		mats_sent++;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the sender until every predicted result has been checked.
	task automatic wait_for_drain();
		while (quats_seen < mats_sent)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold when a test asks for one.
	initial begin : receiver
		int unsigned stall;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold_req) @(posedge clk);
				rx_hold_req = 0;
				m_axis_tready <= 1'b1;
			end else begin
				stall = rx_stalls_on ? pick_gap() : 0;
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare every result transaction against the oldest prediction.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'({m_axis_tuser, m_axis_tdata});
			quats_seen++;
			if (quat_expected.size() == 0) begin
				$error("result transaction with none expected: tdata %h tuser %h",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = quat_expected.pop_front();
				check_field("quat_x", $signed(want.qx), $signed(got.qx));
				check_field("quat_y", $signed(want.qy), $signed(got.qy));
				check_field("quat_z", $signed(want.qz), $signed(got.qz));
				check_field("quat_w", $signed(want.qw), $signed(got.qw));
				check_field("dominant_case", want.dc, got.dc);
				check_field("bad_input", want.bad, got.bad);
			end
		end
	end

	// Give up once nothing has moved on either side for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One matrix per dominant case, plus both sides of each threshold.
	task automatic test_case_select();
		send_matrix(make_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
		send_matrix(make_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		send_matrix(make_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		send_matrix(make_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		send_matrix(make_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
		// m22 zero: a zero diagonal sum still selects w, minus one selects z.
		send_matrix(make_mat(0, 5, -7, 9, 0, 3, -2, 4, 0));
		send_matrix(make_mat(-1, 5, -7, 9, 0, 3, -2, 4, 0));
		// m22 negative: a zero difference selects y, plus one selects x.
		send_matrix(make_mat(100, 11, -13, 17, 100, -19, 23, -29, -1));
		send_matrix(make_mat(101, 11, -13, 17, 100, -19, 23, -29, -1));
		send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Field extremes, largest pivots and saturation in both directions.
	task automatic test_entry_extremes();
		send_matrix(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767));
		send_matrix(make_mat(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768));
		send_matrix(make_mat(32767, -32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767));
		send_matrix(make_mat(-32768, 32767, 32767, 32767, -32768, 32767,
			32767, 32767, 32767));
		send_matrix(make_mat(32767, 32767, -32768, 32767, -32768, 32767,
			-32768, 32767, -32768));
		send_matrix(make_mat(-32768, -32768, 32767, -32768, 32767, -32768,
			32767, -32768, -32768));
		send_matrix(make_mat(16384, -32768, 32767, 32767, 16384, -32768,
			-32768, 32767, 16384));
		send_matrix(make_mat(16384, 32767, -32768, -32768, 16384, 32767,
			32767, -32768, 16384));
	endtask

	// Mix of true rotations, noisy rotations, raw noise and threshold cases.
	task automatic test_random_matrices(input int unsigned count, input bit gaps,
			input bit stalls);
		int unsigned roll;
		tx_gaps_on = gaps;
		rx_stalls_on = stalls;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				send_matrix(random_rotation(1'b0));
			else if (roll < 55)
				send_matrix(random_rotation(1'b1));
			else if (roll < 80)
				send_matrix(mat_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)}));
			else
				send_matrix(near_threshold());
		end
	endtask

	// Freeze the receiver while the sender keeps offering, so the pipeline
	// fills and backs up into the input.
	task automatic test_output_stall();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		repeat (80)
			send_matrix(random_rotation(1'b0));
	endtask

	// Let everything drain mid stream, then restart from an empty pipeline.
	task automatic test_drain_pause();
		test_random_matrices(100, 1'b1, 1'b1);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_for_drain();
		test_random_matrices(300, 1'b1, 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_case_select();
		test_entry_extremes();
		test_random_matrices(400, 1'b1, 1'b1);
		test_random_matrices(400, 1'b0, 1'b0);
		test_random_matrices(300, 1'b1, 1'b0);
		test_random_matrices(300, 1'b0, 1'b1);
		test_output_stall();
		test_drain_pause();

		// Stop offering, collect the tail and watch for stray results.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_for_drain();
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatches == 0 && quat_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
